@@ rtl/dcm_pkg.sv @@
// Shared types, constants and helpers for the DC motor step block.
// Used by every module under rtl; depends on nothing.
`default_nettype none
package dcm_pkg;

  localparam int DATA_W = 32;
  localparam int REG_W  = 31;
  localparam int SAT_W  = 68;
  localparam int IN_W   = 64;
  localparam int OUT_W  = 296;
  localparam int ADDR_W = 5;

  localparam logic signed [SAT_W-1:0] SAT_MAX = 68'sd2147483647;
  localparam logic signed [SAT_W-1:0] SAT_MIN = -68'sd2147483648;

  typedef enum logic [2:0] {
    REG_KT      = 3'd0,
    REG_RES     = 3'd1,
    REG_DAMP    = 3'd2,
    REG_INERTIA = 3'd3,
    REG_VMAX    = 3'd4,
    REG_TSTEP   = 3'd5
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_OK           = 2'd0,
    ST_RES_ZERO     = 2'd1,
    ST_INERTIA_ZERO = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_BEMF, OP_MT, OP_DAMP, OP_NVEL, OP_EP, OP_MP, OP_CUR, OP_ACC, OP_EFF
  } op_t;

  typedef enum logic [4:0] {
    S_IDLE, S_BEMF, S_BEMF_WR, S_CUR_GO, S_CUR, S_MT, S_MT_WR, S_DAMP, S_DAMP_WR,
    S_ACC_GO, S_ACC, S_NVEL, S_NVEL_WR, S_EP, S_EP_WR, S_MP, S_MP_WR, S_EFF_GO,
    S_EFF, S_FIN
  } state_t;

  typedef struct packed {
    logic [REG_W-1:0] kt;
    logic [REG_W-1:0] res;
    logic [REG_W-1:0] damp;
    logic [REG_W-1:0] inertia;
    logic [REG_W-1:0] vmax;
    logic [REG_W-1:0] tstep;
  } cfg_t;

  typedef struct packed {
    logic    load;
    op_t     mul_op;
    op_t     wr_op;
    logic    div_go;
    op_t     div_op;
    logic    fin;
    status_t status;
  } cmd_t;

  typedef struct packed {
    logic res_zero;
    logic inertia_zero;
    logic div_done;
    logic eff_en;
  } sts_t;

  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [SAT_W-1:0] v);
    logic signed [DATA_W-1:0] r;
    if (v > SAT_MAX) r = SAT_MAX[DATA_W-1:0];
    else if (v < SAT_MIN) r = SAT_MIN[DATA_W-1:0];
    else r = v[DATA_W-1:0];
    return r;
  endfunction

endpackage
`default_nettype wire

@@ rtl/dc_motor_model_step.sv @@
// DC motor model, one forward-Euler step per item.
// Slave stream: s_tdata carries the voltage request and the load torque; each
// accepted item produces exactly one result item on the master stream, which
// carries the clamped voltage, back-EMF, current, torques, the new angular
// velocity, electrical and mechanical power, efficiency and a status code.
// Configuration registers sit on the APB port; the user must write them only
// while idle, and the block itself does not enforce it. The three divisions
// run one after another on the shared two-bit-per-cycle divider. When the
// efficiency is not computed its division is skipped, and an error status
// skips the rest of the chain. One item is in work at a time.
// The result register holds a finished item while the receiver stalls; the
// next item is accepted meanwhile and waits at its end until the register frees.
// Reset clears the velocity to zero and loads the register defaults
// (resistance 1.0, inertia 1.0, time step 0.01, others 0).
// Depends on dcm_pkg, dcm_ctrl, dcm_dp and dcm_div.
`default_nettype none
module dc_motor_model_step #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           s_tvalid,
  output logic                                s_tready,
  // voltage_request[31:0], load_torque[63:32]
  input  wire logic [dcm_pkg::IN_W-1:0]       s_tdata,
  output logic                                m_tvalid,
  input  wire logic                           m_tready,
  // applied_voltage, back_emf, phase_current, motor_torque, net_torque,
  // angular_speed, electrical_power, mechanical_power, efficiency_ratio
  // (32 bits each from bit 0), status[289:288], zero fill
  output logic [dcm_pkg::OUT_W-1:0]           m_tdata,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [dcm_pkg::ADDR_W-1:0]     paddr,
  input  wire logic [31:0]                    pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready
);
  import dcm_pkg::*;

  cfg_t     cfg;
  cmd_t     cmd;
  sts_t     sts;
  reg_idx_t idx;

  assign pready = 1'b1;
  assign idx    = reg_idx_t'(paddr[4:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.kt      <= '0;
      cfg.res     <= REG_W'(1 << FRAC_BITS);
      cfg.damp    <= '0;
      cfg.inertia <= REG_W'(1 << FRAC_BITS);
      cfg.vmax    <= '0;
      cfg.tstep   <= REG_W'(((1 << FRAC_BITS) + 50) / 100);
    end else if (psel && penable && pwrite && pready) begin
      case (idx)
        REG_KT:      cfg.kt      <= pwdata[REG_W-1:0];
        REG_RES:     cfg.res     <= pwdata[REG_W-1:0];
        REG_DAMP:    cfg.damp    <= pwdata[REG_W-1:0];
        REG_INERTIA: cfg.inertia <= pwdata[REG_W-1:0];
        REG_VMAX:    cfg.vmax    <= pwdata[REG_W-1:0];
        REG_TSTEP:   cfg.tstep   <= pwdata[REG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_KT:      prdata = {1'b0, cfg.kt};
      REG_RES:     prdata = {1'b0, cfg.res};
      REG_DAMP:    prdata = {1'b0, cfg.damp};
      REG_INERTIA: prdata = {1'b0, cfg.inertia};
      REG_VMAX:    prdata = {1'b0, cfg.vmax};
      REG_TSTEP:   prdata = {1'b0, cfg.tstep};
      default:     prdata = '0;
    endcase
  end

  dcm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  dcm_dp #(.FRAC_BITS(FRAC_BITS)) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .cmd      (cmd),
    .sts      (sts),
    .in_data  (s_tdata),
    .out_data (m_tdata)
  );

endmodule
`default_nettype wire

@@ rtl/dcm_div.sv @@
// Signed fixed-point divider, two quotient bits per cycle (restoring).
// Returns sat32((num << FRAC_BITS) / den) truncated toward zero; uses dcm_pkg.
`default_nettype none
module dcm_div #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               go,
  input  wire logic signed [32:0] num,
  input  wire logic [31:0]        den,
  output logic                    done,
  output logic signed [31:0]      quo
);
  import dcm_pkg::*;

  localparam int NW    = 33 + FRAC_BITS;
  localparam int NW2   = NW + (NW % 2);
  localparam int STEPS = NW2 / 2;
  localparam int CNT_W = $clog2(STEPS + 1);

  logic [NW2-1:0]   q;
  logic [31:0]      rem;
  logic [31:0]      dsr;
  logic             neg;
  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic             done_r;

  logic [32:0] mag;
  logic [32:0] r0, r2;
  logic [33:0] t0, t1;
  logic        ge0, ge1;
  logic [31:0] r1, r3;
  logic        hi;

  always_comb begin
    mag = num[32] ? 33'(-num) : num;
    r0  = {rem, q[NW2-1]};
    t0  = {1'b0, r0} - {2'b0, dsr};
    ge0 = !t0[33];
    r1  = ge0 ? t0[31:0] : r0[31:0];
    r2  = {r1, q[NW2-2]};
    t1  = {1'b0, r2} - {2'b0, dsr};
    ge1 = !t1[33];
    r3  = ge1 ? t1[31:0] : r2[31:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy   <= 1'b0;
      done_r <= 1'b0;
      cnt    <= '0;
    end else begin
      done_r <= 1'b0;
      if (go) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(STEPS);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy   <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      q   <= NW2'({mag, {FRAC_BITS{1'b0}}});
      rem <= '0;
      dsr <= den;
      neg <= num[32];
    end else if (busy) begin
      q   <= {q[NW2-3:0], ge0, ge1};
      rem <= r3;
    end
  end

  // saturate the magnitude, then apply the sign
  always_comb begin
    hi = |q[NW2-1:32];
    if (neg) begin
      if (hi || (q[31] && |q[30:0])) quo = SAT_MIN[31:0];
      else quo = 32'(-q[31:0]);
    end else begin
      if (hi || q[31]) quo = SAT_MAX[31:0];
      else quo = q[31:0];
    end
  end

  assign done = done_r;

endmodule
`default_nettype wire

@@ rtl/dcm_dp.sv @@
// Datapath: item registers, shared multiplier, divider and result register.
// Driven by dcm_ctrl through cmd_t; uses dcm_pkg and dcm_div.
`default_nettype none
module dcm_dp #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire dcm_pkg::cfg_t                 cfg,
  input  wire dcm_pkg::cmd_t                 cmd,
  output dcm_pkg::sts_t                      sts,
  input  wire logic [dcm_pkg::IN_W-1:0]      in_data,
  output logic [dcm_pkg::OUT_W-1:0]          out_data
);
  import dcm_pkg::*;

  localparam int EFF_THR_I = ((1 << FRAC_BITS) + 50) / 100;
  localparam logic signed [31:0] EFF_THR = 32'(EFF_THR_I);

  logic signed [31:0] vel, applied, load_r, bemf, cur, mt, net, acc, nvel, ep, mp, eff;
  logic signed [65:0] prod;
  logic signed [32:0] ma, mb;
  logic signed [SAT_W-1:0] prod_sc;
  op_t div_dst;

  logic signed [32:0] vx, pv, nv;
  logic signed [31:0] vreq, clamp;

  logic               div_go;
  logic signed [32:0] div_num;
  logic [31:0]        div_den;
  logic               div_done;
  logic signed [31:0] div_quo;

  // clamp the request to +/- max voltage
  always_comb begin
    vreq = in_data[31:0];
    vx   = 33'(vreq);
    pv   = $signed({2'b0, cfg.vmax});
    nv   = -pv;
    if (vx > pv) clamp = pv[31:0];
    else if (vx < nv) clamp = nv[31:0];
    else clamp = vreq;
  end

  always_comb begin
    case (cmd.mul_op)
      OP_BEMF: begin ma = $signed({2'b0, cfg.kt});   mb = 33'(vel);   end
      OP_MT:   begin ma = $signed({2'b0, cfg.kt});   mb = 33'(cur);   end
      OP_DAMP: begin ma = $signed({2'b0, cfg.damp}); mb = 33'(vel);   end
      OP_NVEL: begin ma = 33'(acc); mb = $signed({2'b0, cfg.tstep});  end
      OP_EP:   begin ma = 33'(applied); mb = 33'(cur); end
      OP_MP:   begin ma = 33'(mt);      mb = 33'(nvel); end
      default: begin ma = '0; mb = '0; end
    endcase
  end

  assign prod_sc = SAT_W'(prod) >>> FRAC_BITS;

  always_comb begin
    div_go = cmd.div_go;
    case (cmd.div_op)
      OP_CUR:  begin div_num = 33'(applied) - 33'(bemf); div_den = {1'b0, cfg.res}; end
      OP_ACC:  begin div_num = 33'(net); div_den = {1'b0, cfg.inertia}; end
      OP_EFF:  begin div_num = 33'(mp);  div_den = ep; end
      default: begin div_num = '0; div_den = '0; end
    endcase
  end

  dcm_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk  (clk),
    .rst  (rst),
    .go   (div_go),
    .num  (div_num),
    .den  (div_den),
    .done (div_done),
    .quo  (div_quo)
  );

  always_ff @(posedge clk) begin
    if (rst) vel <= '0;
    else if (cmd.fin) vel <= nvel;
  end

  always_ff @(posedge clk) begin
    prod <= ma * mb;
    if (cmd.div_go) div_dst <= cmd.div_op;
    if (cmd.load) begin
      applied <= clamp;
      load_r  <= in_data[63:32];
      cur     <= '0;
      mt      <= '0;
      net     <= '0;
      ep      <= '0;
      mp      <= '0;
      eff     <= '0;
      nvel    <= vel;
    end else begin
      case (cmd.wr_op)
        OP_BEMF: bemf <= sat32(prod_sc);
        OP_MT:   mt   <= sat32(prod_sc);
        OP_DAMP: net  <= sat32(SAT_W'(mt) - SAT_W'(load_r) - prod_sc);
        OP_NVEL: nvel <= sat32(SAT_W'(vel) + prod_sc);
        OP_EP:   ep   <= sat32(prod_sc);
        OP_MP:   mp   <= sat32(prod_sc);
        default: ;
      endcase
      if (div_done) begin
        case (div_dst)
          OP_CUR:  cur <= div_quo;
          OP_ACC:  acc <= div_quo;
          OP_EFF:  eff <= div_quo;
          default: ;
        endcase
      end
    end
    if (cmd.fin)
      out_data <= {6'b0, cmd.status, eff, mp, ep, nvel, net, mt, cur, bemf, applied};
  end

  always_comb begin
    sts.res_zero     = (cfg.res == '0);
    sts.inertia_zero = (cfg.inertia == '0);
    sts.div_done     = div_done;
    sts.eff_en       = (ep > EFF_THR);
  end

endmodule
`default_nettype wire

@@ rtl/dcm_ctrl.sv @@
// Sequencer for one motor step: orders multiplies, divides and the result load.
// Talks to dcm_dp through cmd_t and sts_t; uses dcm_pkg.
`default_nettype none
module dcm_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          s_tvalid,
  output logic               s_tready,
  output logic               m_tvalid,
  input  wire logic          m_tready,
  input  wire dcm_pkg::sts_t sts,
  output dcm_pkg::cmd_t      cmd
);
  import dcm_pkg::*;

  state_t  state, state_next;
  status_t st_r, st_next;
  logic    out_valid, out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      st_r      <= ST_OK;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      st_r      <= st_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    st_next    = st_r;
    cmd.load   = 1'b0;
    cmd.mul_op = OP_NONE;
    cmd.wr_op  = OP_NONE;
    cmd.div_go = 1'b0;
    cmd.div_op = OP_NONE;
    cmd.fin    = 1'b0;
    cmd.status = st_r;
    s_tready   = (state == S_IDLE);
    case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          st_next    = ST_OK;
          state_next = S_BEMF;
        end
      end
      S_BEMF: begin
        cmd.mul_op = OP_BEMF;
        state_next = S_BEMF_WR;
      end
      S_BEMF_WR: begin
        cmd.wr_op = OP_BEMF;
        if (sts.res_zero) begin
          st_next    = ST_RES_ZERO;
          state_next = S_FIN;
        end else begin
          state_next = S_CUR_GO;
        end
      end
      S_CUR_GO: begin
        cmd.div_go = 1'b1;
        cmd.div_op = OP_CUR;
        state_next = S_CUR;
      end
      S_CUR: if (sts.div_done) state_next = S_MT;
      S_MT: begin
        cmd.mul_op = OP_MT;
        state_next = S_MT_WR;
      end
      S_MT_WR: begin
        cmd.wr_op  = OP_MT;
        state_next = S_DAMP;
      end
      S_DAMP: begin
        cmd.mul_op = OP_DAMP;
        state_next = S_DAMP_WR;
      end
      S_DAMP_WR: begin
        cmd.wr_op = OP_DAMP;
        if (sts.inertia_zero) begin
          st_next    = ST_INERTIA_ZERO;
          state_next = S_FIN;
        end else begin
          state_next = S_ACC_GO;
        end
      end
      S_ACC_GO: begin
        cmd.div_go = 1'b1;
        cmd.div_op = OP_ACC;
        state_next = S_ACC;
      end
      S_ACC: if (sts.div_done) state_next = S_NVEL;
      S_NVEL: begin
        cmd.mul_op = OP_NVEL;
        state_next = S_NVEL_WR;
      end
      S_NVEL_WR: begin
        cmd.wr_op  = OP_NVEL;
        state_next = S_EP;
      end
      S_EP: begin
        cmd.mul_op = OP_EP;
        state_next = S_EP_WR;
      end
      S_EP_WR: begin
        cmd.wr_op  = OP_EP;
        state_next = S_MP;
      end
      S_MP: begin
        cmd.mul_op = OP_MP;
        state_next = S_MP_WR;
      end
      S_MP_WR: begin
        cmd.wr_op  = OP_MP;
        state_next = S_EFF_GO;
      end
      S_EFF_GO: begin
        if (sts.eff_en) begin
          cmd.div_go = 1'b1;
          cmd.div_op = OP_EFF;
          state_next = S_EFF;
        end else begin
          state_next = S_FIN;
        end
      end
      S_EFF: if (sts.div_done) state_next = S_FIN;
      S_FIN: begin
        // hold until the result register is free
        if (!out_valid || m_tready) begin
          cmd.fin    = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
    if (cmd.fin) out_valid_next = 1'b1;
    else if (m_tready) out_valid_next = 1'b0;
    else out_valid_next = out_valid;
    m_tvalid = out_valid;
  end

endmodule
`default_nettype wire

@@ rtl/dcm_chk.sv @@
// Port-level checks for the DC motor step block, bound to the top level.
// Sees only the result stream ports; uses dcm_pkg for widths and status codes.
`default_nettype none
module dcm_chk #(
  parameter int FRAC_BITS = 16
) (
  input wire logic                     clk,
  input wire logic                     rst,
  input wire logic                     m_tvalid,
  input wire logic                     m_tready,
  input wire logic [dcm_pkg::OUT_W-1:0] m_tdata
);
  import dcm_pkg::*;

  localparam int EFF_THR_I = ((1 << FRAC_BITS) + 50) / 100;
  localparam logic signed [31:0] EFF_THR = 32'(EFF_THR_I);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result item changed while stalled");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result item shown after reset");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[289:288] <= ST_INERTIA_ZERO)
    else $error("undefined status code");

  a_res_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[289:288] == ST_RES_ZERO |->
      m_tdata[159:64] == '0 && m_tdata[287:192] == '0)
    else $error("coil resistance error with nonzero current or power");

  a_eff_gate: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && ($signed(m_tdata[223:192]) <= EFF_THR) |-> m_tdata[287:256] == '0)
    else $error("efficiency reported below power threshold");

endmodule

bind dc_motor_model_step dcm_chk #(.FRAC_BITS(FRAC_BITS)) u_dcm_chk (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
`default_nettype wire

@@ sim/tb_dc_motor_model_step.sv @@
// Self-checking testbench for dc_motor_model_step: stream stimulus with random idling,
// APB register writes between phases, and a scoreboard that predicts every result item.
// Depends on dcm_pkg and the RTL under rtl.
`default_nettype none

class motor_scoreboard;
  typedef struct packed {
    logic [31:0] vmax;
    logic [31:0] kt;
    logic [31:0] res;
    logic [31:0] damp;
    logic [31:0] inertia;
    logic [31:0] tstep;
  } motor_cfg_t;

  motor_cfg_t cfg;
  logic signed [31:0] omega;
  logic [dcm_pkg::OUT_W-1:0] pending[$];
  int mismatches;

  function new();
    cfg.kt = 0; cfg.res = 65536; cfg.damp = 0; cfg.inertia = 65536;
    cfg.vmax = 0; cfg.tstep = 655;
    omega = 0;
    mismatches = 0;
  endfunction

  function void set_reg(dcm_pkg::reg_idx_t idx, logic [31:0] v);
    logic [31:0] m;
    m = v & 32'h7FFF_FFFF;
    case (idx)
      dcm_pkg::REG_KT:      cfg.kt = m;
      dcm_pkg::REG_RES:     cfg.res = m;
      dcm_pkg::REG_DAMP:    cfg.damp = m;
      dcm_pkg::REG_INERTIA: cfg.inertia = m;
      dcm_pkg::REG_VMAX:    cfg.vmax = m;
      dcm_pkg::REG_TSTEP:   cfg.tstep = m;
      default: ;
    endcase
  endfunction

  // floor of the product scaled down by 16 bits
  function longint fxmul(longint a, longint b);
    longint p;
    p = a * b;
    return p >>> 16;
  endfunction

  function longint fxdiv(longint n, longint d);
    return (n * 65536) / d;
  endfunction

  function longint clip(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function void note_item(logic [63:0] d);
    longint vreq, load, vel, kt, vmax, app, bemf, cur, mt, dmp, net, acc, nvel, ep, mp, eff;
    logic [dcm_pkg::OUT_W-1:0] r;
    dcm_pkg::status_t st;
    vreq = longint'($signed(d[31:0]));
    load = longint'($signed(d[63:32]));
    vel = longint'(omega);
    kt = longint'(cfg.kt);
    vmax = longint'(cfg.vmax);
    cur = 0; mt = 0; net = 0; ep = 0; mp = 0; eff = 0;
    app = vreq;
    if (app > vmax) app = vmax;
    if (app < -vmax) app = -vmax;
    bemf = clip(fxmul(kt, vel));
    nvel = vel;
    st = dcm_pkg::ST_OK;
    if (cfg.res == 0) begin
      st = dcm_pkg::ST_RES_ZERO;
    end else begin
      cur = clip(fxdiv(app - bemf, longint'(cfg.res)));
      mt = clip(fxmul(kt, cur));
      dmp = fxmul(longint'(cfg.damp), vel);
      net = clip(mt - load - dmp);
      if (cfg.inertia == 0) begin
        st = dcm_pkg::ST_INERTIA_ZERO;
      end else begin
        acc = clip(fxdiv(net, longint'(cfg.inertia)));
        nvel = clip(vel + fxmul(acc, longint'(cfg.tstep)));
        omega = nvel[31:0];
        ep = clip(fxmul(app, cur));
        mp = clip(fxmul(mt, nvel));
        if (ep > 655) eff = clip(fxdiv(mp, ep));
      end
    end
    r = '0;
    r[31:0] = app[31:0];
    r[63:32] = bemf[31:0];
    r[95:64] = cur[31:0];
    r[127:96] = mt[31:0];
    r[159:128] = net[31:0];
    r[191:160] = nvel[31:0];
    r[223:192] = ep[31:0];
    r[255:224] = mp[31:0];
    r[287:256] = eff[31:0];
    r[289:288] = st;
    pending.push_back(r);
  endfunction

  function void check_result(logic [dcm_pkg::OUT_W-1:0] got);
    logic [dcm_pkg::OUT_W-1:0] want;
    bit bad;
    if (pending.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected result item %h", got);
      return;
    end
    want = pending.pop_front();
    bad = 0;
    for (int f = 0; f < 9; f++) begin
      if (got[f*32 +: 32] !== want[f*32 +: 32]) begin
        bad = 1;
        if (mismatches < 10)
          $display("field %0d: expected %h, got %h", f, want[f*32 +: 32], got[f*32 +: 32]);
      end
    end
    if (got[289:288] !== want[289:288]) begin
      bad = 1;
      if (mismatches < 10)
        $display("status: expected %h, got %h", want[289:288], got[289:288]);
    end
    if (got[dcm_pkg::OUT_W-1:290] !== '0) bad = 1;
    if (bad) mismatches++;
  endfunction
endclass

module tb_dc_motor_model_step;
  import dcm_pkg::*;

  logic clk, rst;
  logic s_tvalid, s_tready, m_tvalid, m_tready;
  logic [IN_W-1:0] s_tdata;
  logic [OUT_W-1:0] m_tdata;
  logic psel, penable, pwrite, pready;
  logic [ADDR_W-1:0] paddr;
  logic [31:0] pwdata, prdata;

  motor_scoreboard sb;
  bit hold_off;
  bit random_stall;

  dc_motor_model_step DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  initial begin
    #400000000;
    $display("TEST FAILED");
    $finish;
  end

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 50) return 0;
    if (p < 92) return $urandom_range(1, 4);
    return $urandom_range(20, 250);
  endfunction

  task automatic reg_write(reg_idx_t idx, logic [31:0] v);
    @(posedge clk);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= ADDR_W'(4 * int'(idx)); pwdata <= v;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    sb.set_reg(idx, v);
  endtask

  // valid stays high after an accept and drops only at the start of a gap or when draining
  task automatic send_item(logic [31:0] vreq, logic [31:0] load);
    int g;
    g = random_stall ? gap_len() : 0;
    if (g > 0) begin
      s_tvalid <= 0;
      repeat (g) @(posedge clk);
    end
    s_tvalid <= 1;
    s_tdata <= {load, vreq};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_item({load, vreq});
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    s_tvalid <= 0;
    while (sb.pending.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (150) @(posedge clk);
  endtask

  // receiver: random stalls, plus one long hold-off when asked
  initial begin
    m_tready = 0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (m_tvalid && m_tready) sb.check_result(m_tdata);
      if (hold_off) m_tready <= 0;
      else if (random_stall) m_tready <= ($urandom_range(0, 3) != 0);
      else m_tready <= 1;
    end
  end

  function automatic logic [31:0] rnd_val();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return 32'h7FFF_FFFF;
      2: return 32'h8000_0000;
      3: return 32'($signed($urandom_range(0, 2000000)) - 1000000);
      default: return 32'($signed($urandom_range(0, 600000)) - 300000);
    endcase
  endfunction

  task automatic random_phase(int n);
    for (int i = 0; i < n; i++) send_item(rnd_val(), rnd_val());
  endtask

  initial begin
    sb = new();
    rst = 1; s_tvalid = 0; s_tdata = '0;
    psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
    hold_off = 0; random_stall = 0;
    repeat (6) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: defaults, then extremes and both error statuses
    send_item(32'h0001_0000, 32'h0);
    drain();
    reg_write(REG_KT, 32'h0000_8000);
    reg_write(REG_VMAX, 32'h000C_0000);
    reg_write(REG_DAMP, 32'h0000_0800);
    send_item(32'h7FFF_FFFF, 32'h0);
    send_item(32'h8000_0000, 32'h7FFF_FFFF);
    send_item(32'h0005_0000, 32'h8000_0000);
    send_item(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    drain();
    reg_write(REG_RES, 32'h0);
    send_item(32'h0003_0000, 32'h0001_0000);
    drain();
    reg_write(REG_RES, 32'hFFFF_FFFF);
    reg_write(REG_INERTIA, 32'h0);
    send_item(32'h0003_0000, 32'h0001_0000);
    drain();
    reg_write(REG_RES, 32'h0000_0001);
    reg_write(REG_INERTIA, 32'h0000_0001);
    reg_write(REG_TSTEP, 32'h7FFF_FFFF);
    reg_write(REG_VMAX, 32'h7FFF_FFFF);
    reg_write(REG_KT, 32'h7FFF_FFFF);
    send_item(32'h7FFF_FFFF, 32'h8000_0000);
    send_item(32'h8000_0000, 32'h7FFF_FFFF);
    send_item(32'h1234_5678, 32'h0);
    drain();

    random_stall = 1;
    for (int ph = 0; ph < 7; ph++) begin
      reg_write(REG_KT, (ph == 0) ? 32'h0 : ((ph == 1) ? 32'hFFFF_FFFF :
                ($urandom_range(0, 1) ? $urandom : $urandom_range(1000, 200000))));
      reg_write(REG_RES, (ph == 2) ? 32'h0 : $urandom_range(1000, 300000));
      reg_write(REG_DAMP, (ph == 3) ? 32'h7FFF_FFFF : $urandom_range(0, 20000));
      reg_write(REG_INERTIA, (ph == 4) ? 32'h0 : $urandom_range(100, 200000));
      reg_write(REG_VMAX, (ph == 5) ? 32'h0 : $urandom);
      reg_write(REG_TSTEP, (ph == 6) ? 32'h0 : $urandom_range(1, 70000));
      if (ph == 1) begin
        fork
          begin
            hold_off = 1;
            repeat (3000) @(posedge clk);
            hold_off = 0;
          end
          random_phase(250);
        join
      end else begin
        random_phase(250);
      end
      drain();
    end

    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule

`default_nettype wire
